/* src/sv32ptw_pkg.sv */
`timescale 1ns / 1ps

package sv32ptw_pkg;

    localparam int unsigned XLEN       = 32;
    localparam int unsigned PPN_W      = 22;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned PAGE_OFS_W = 12;
    localparam int unsigned VPN_W      = 10;

    // Low PPN bits that survive the 32-bit cut of ppn * 4096
    localparam int unsigned BASE_W     = XLEN - PAGE_OFS_W;

    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_RESPONSE  = 1'b1;

    localparam logic KIND_MEM_REQ = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CROSS_PAGE = 2'd2;

    typedef struct packed {
        logic                cmd;
        logic [XLEN-1:0]     vaddr;
        logic [LEN_W-1:0]    access_len;
        logic [XLEN-1:0]     read_data;
    } t_item;

    typedef struct packed {
        logic                kind;
        logic [XLEN-1:0]     phys_addr;
        logic [STATUS_W-1:0] status;
    } t_result;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_L1   = 3'b010,
        PH_L0   = 3'b100
    } t_phase;

endpackage

/* src/sv32ptw_walk.sv */
`timescale 1ns / 1ps

module sv32ptw_walk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  sv32ptw_pkg::t_item                 i_item,
    input  logic [sv32ptw_pkg::PPN_W-1:0]      i_root_ppn,
    output logic                               o_has_result,
    output sv32ptw_pkg::t_result               o_result
);

    sv32ptw_pkg::t_phase                     r_phase, n_phase;
    logic [sv32ptw_pkg::XLEN-1:0]            r_held_vaddr;
    logic [sv32ptw_pkg::LEN_W-1:0]           r_held_len;

    logic                                    idle;
    logic [sv32ptw_pkg::VPN_W-1:0]           vpn1;
    logic [sv32ptw_pkg::VPN_W-1:0]           vpn0;
    logic [sv32ptw_pkg::PAGE_OFS_W-1:0]      offset;
    logic [sv32ptw_pkg::PAGE_OFS_W:0]        ofs_end;
    logic [sv32ptw_pkg::BASE_W-1:0]          root_base;
    logic [sv32ptw_pkg::BASE_W-1:0]          pte_base;

    assign idle      = (r_phase != sv32ptw_pkg::PH_L1) && (r_phase != sv32ptw_pkg::PH_L0);
    assign vpn1      = i_item.vaddr[31:22];
    assign vpn0      = r_held_vaddr[21:12];
    assign offset    = r_held_vaddr[sv32ptw_pkg::PAGE_OFS_W-1:0];
    assign ofs_end   = {1'b0, offset} + {{(sv32ptw_pkg::PAGE_OFS_W + 1
                       - sv32ptw_pkg::LEN_W){1'b0}}, r_held_len};
    assign root_base = i_root_ppn[sv32ptw_pkg::BASE_W-1:0];
    assign pte_base  = i_item.read_data[sv32ptw_pkg::BASE_W+9:10];

    always_comb begin
        o_has_result       = 1'b0;
        o_result.kind      = sv32ptw_pkg::KIND_MEM_REQ;
        o_result.phys_addr = '0;
        o_result.status    = sv32ptw_pkg::STATUS_OK;
        n_phase            = r_phase;
        if (i_item.cmd == sv32ptw_pkg::CMD_TRANSLATE) begin
            if (idle) begin
                o_has_result       = 1'b1;
                o_result.phys_addr = {root_base, {sv32ptw_pkg::PAGE_OFS_W{1'b0}}}
                                   + {20'b0, vpn1, 2'b00};
                n_phase            = sv32ptw_pkg::PH_L1;
            end
        end else if (!idle) begin
            o_has_result = 1'b1;
            if (!i_item.read_data[0]) begin
                o_result.kind   = sv32ptw_pkg::KIND_DONE;
                o_result.status = sv32ptw_pkg::STATUS_INVALID;
                n_phase         = sv32ptw_pkg::PH_IDLE;
            end else if (r_phase == sv32ptw_pkg::PH_L1) begin
                o_result.phys_addr = {pte_base, {sv32ptw_pkg::PAGE_OFS_W{1'b0}}}
                                   + {20'b0, vpn0, 2'b00};
                n_phase            = sv32ptw_pkg::PH_L0;
            end else begin
                o_result.kind = sv32ptw_pkg::KIND_DONE;
                n_phase       = sv32ptw_pkg::PH_IDLE;
                // offset + len beyond one page: report a page crossing
                if (ofs_end > 13'd4096) begin
                    o_result.status = sv32ptw_pkg::STATUS_CROSS_PAGE;
                end else begin
                    o_result.phys_addr = {pte_base, offset};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sv32ptw_pkg::PH_IDLE;
        end else if (i_adv) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && idle && i_item.cmd == sv32ptw_pkg::CMD_TRANSLATE) begin
            r_held_vaddr <= i_item.vaddr;
            r_held_len   <= i_item.access_len;
        end
    end

endmodule

/* src/sv32ptw_out_reg.sv */
`timescale 1ns / 1ps

module sv32ptw_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  sv32ptw_pkg::t_result  i_result,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic                  o_free,
    output sv32ptw_pkg::t_result  o_result
);

    logic                  r_valid;
    sv32ptw_pkg::t_result  r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* src/sv32_page_table_walker_top.sv */
`timescale 1ns / 1ps

// Sv32 two-level page table walker.
// Input channel (i_valid / o_ready): cmd 0 starts a translation of i_vaddr
// with length i_access_len; cmd 1 returns a PTE word from memory on
// i_read_data. Items that arrive in the wrong walk phase are dropped.
// Output channel (o_valid / i_ready): kind 0 asks memory for the PTE at
// o_phys_addr; kind 1 ends the walk with o_status (ok, invalid entry,
// crosses page) and, when ok, the physical address.
// Config channel (i_cfg_valid / o_cfg_ready) loads the root table PPN; it is
// always ready; the user writes it only while no walk is in flight (not enforced).
// An accepted item waits in the input register; when it advances, its result
// is loaded into the output register, which drives the output.
// Throughput: one item per cycle; the input register and the output
// register each take a new item while the one ahead of them moves on.
// When the receiver stalls, the output register holds its item, the input
// register fills behind it and then o_ready drops.
// Reset: walk returns to idle, both registers empty, root PPN cleared.
module sv32_page_table_walker_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_cmd,
    input  logic [sv32ptw_pkg::XLEN-1:0]          i_vaddr,
    input  logic [sv32ptw_pkg::LEN_W-1:0]         i_access_len,
    input  logic [sv32ptw_pkg::XLEN-1:0]          i_read_data,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_kind,
    output logic [sv32ptw_pkg::XLEN-1:0]          o_phys_addr,
    output logic [sv32ptw_pkg::STATUS_W-1:0]      o_status,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sv32ptw_pkg::PPN_W-1:0]         i_cfg_root_ppn
);

    logic                                r_in_valid;
    sv32ptw_pkg::t_item                  r_in_item;
    logic [sv32ptw_pkg::PPN_W-1:0]       r_root_ppn;

    logic                                has_result;
    logic                                out_free;
    logic                                adv;
    sv32ptw_pkg::t_result                walk_result;
    sv32ptw_pkg::t_result                out_result;

    // Advance the held item when it makes no result or the output has room
    assign adv         = r_in_valid && (!has_result || out_free);
    assign o_ready     = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_item.cmd        <= i_cmd;
            r_in_item.vaddr      <= i_vaddr;
            r_in_item.access_len <= i_access_len;
            r_in_item.read_data  <= i_read_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_ppn <= '0;
        end else if (i_cfg_valid) begin
            r_root_ppn <= i_cfg_root_ppn;
        end
    end

    sv32ptw_walk u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_item       (r_in_item),
        .i_root_ppn   (r_root_ppn),
        .o_has_result (has_result),
        .o_result     (walk_result)
    );

    sv32ptw_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv && has_result),
        .i_result (walk_result),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_kind      = out_result.kind;
    assign o_phys_addr = out_result.phys_addr;
    assign o_status    = out_result.status;

endmodule

/* dv/ptw_walk_checker.sv */
`timescale 1ns / 1ps

module ptw_walk_checker
    import sv32ptw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_cmd,
    input  logic [XLEN-1:0]     i_vaddr,
    input  logic [LEN_W-1:0]    i_access_len,
    input  logic [XLEN-1:0]     i_read_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic                i_kind,
    input  logic [XLEN-1:0]     i_phys_addr,
    input  logic [STATUS_W-1:0] i_status,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [PPN_W-1:0]    i_cfg_root_ppn,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int unsigned PTE_PPN_LSB = 10;
    localparam int unsigned PAGE_BYTES  = 1 << PAGE_OFS_W;

    logic [PPN_W-1:0] root_ppn_q;
    t_phase           phase_q;
    logic [XLEN-1:0]  vaddr_q;
    logic [LEN_W-1:0] len_q;
    t_result          expected_results[$];

    // Advance the walk by one accepted item; return 1 when it yields a result.
    function automatic bit walk_step(input t_item item, output t_result res);
        logic [VPN_W-1:0]      vpn;
        logic [PAGE_OFS_W-1:0] offset;
        int unsigned           span;
        res = '0;
        if (item.cmd == CMD_TRANSLATE) begin
            if (phase_q == PH_L1 || phase_q == PH_L0) begin
                return 1'b0;
            end
            vaddr_q = item.vaddr;
            len_q   = item.access_len;
            phase_q = PH_L1;
            vpn = item.vaddr[XLEN-1 -: VPN_W];
            res.kind      = KIND_MEM_REQ;
            res.phys_addr = {root_ppn_q[BASE_W-1:0], {PAGE_OFS_W{1'b0}}}
                            + {{(XLEN-VPN_W-2){1'b0}}, vpn, 2'b00};
            res.status    = STATUS_OK;
            return 1'b1;
        end
        // Drop a response that arrives while no walk is in flight.
        if (phase_q != PH_L1 && phase_q != PH_L0) begin
            return 1'b0;
        end
        if (!item.read_data[0]) begin
            phase_q    = PH_IDLE;
            res.kind   = KIND_DONE;
            res.status = STATUS_INVALID;
            return 1'b1;
        end
        if (phase_q == PH_L1) begin
            vpn = vaddr_q[PAGE_OFS_W +: VPN_W];
            phase_q = PH_L0;
            res.kind      = KIND_MEM_REQ;
            res.phys_addr = {item.read_data[PTE_PPN_LSB +: BASE_W], {PAGE_OFS_W{1'b0}}}
                            + {{(XLEN-VPN_W-2){1'b0}}, vpn, 2'b00};
            res.status    = STATUS_OK;
            return 1'b1;
        end
        phase_q = PH_IDLE;
        offset  = vaddr_q[PAGE_OFS_W-1:0];
        span    = offset + len_q;
        res.kind = KIND_DONE;
        if (span > PAGE_BYTES) begin
            res.status = STATUS_CROSS_PAGE;
        end else begin
            res.phys_addr = {item.read_data[PTE_PPN_LSB +: BASE_W], offset};
            res.status    = STATUS_OK;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_item   item;
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            root_ppn_q = '0;
            phase_q    = PH_IDLE;
            vaddr_q    = '0;
            len_q      = '0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            // Retire first: an item accepted at this edge cannot leave at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d phys_addr %h status %0d",
                           i_kind, i_phys_addr, i_status);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_kind !== want.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d", want.kind, i_kind);
                        o_fail_count++;
                    end
                    if (i_phys_addr !== want.phys_addr) begin
                        $error("phys_addr mismatch: expected %h, actual %h",
                               want.phys_addr, i_phys_addr);
                        o_fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                root_ppn_q = i_cfg_root_ppn;
            end
            if (i_in_valid && i_in_ready) begin
                item.cmd        = i_cmd;
                item.vaddr      = i_vaddr;
                item.access_len = i_access_len;
                item.read_data  = i_read_data;
                if (walk_step(item, pred)) begin
                    expected_results.push_back(pred);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import sv32ptw_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int WALKS_PER_PHASE = 36;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic                i_cmd = CMD_TRANSLATE;
    logic [XLEN-1:0]     i_vaddr = '0;
    logic [LEN_W-1:0]    i_access_len = '0;
    logic [XLEN-1:0]     i_read_data = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_kind;
    logic [XLEN-1:0]     o_phys_addr;
    logic [STATUS_W-1:0] o_status;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [PPN_W-1:0]    i_cfg_root_ppn = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    sv32_page_table_walker_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_vaddr        (i_vaddr),
        .i_access_len   (i_access_len),
        .i_read_data    (i_read_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_phys_addr    (o_phys_addr),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_root_ppn (i_cfg_root_ppn)
    );

    ptw_walk_checker u_walk_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_cmd          (i_cmd),
        .i_vaddr        (i_vaddr),
        .i_access_len   (i_access_len),
        .i_read_data    (i_read_data),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_kind         (o_kind),
        .i_phys_addr    (o_phys_addr),
        .i_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_root_ppn (i_cfg_root_ppn),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Memory side: stall the result channel in random bursts.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < recv_stall_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // Entered and left at a falling edge; valid stays high into the next item.
    task automatic send_item(input logic cmd, input logic [XLEN-1:0] va,
                             input logic [LEN_W-1:0] len, input logic [XLEN-1:0] pte);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_vaddr      <= va;
        i_access_len <= len;
        i_read_data  <= pte;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_translate(input logic [XLEN-1:0] va, input logic [LEN_W-1:0] len);
        send_item(CMD_TRANSLATE, va, len, $urandom);
    endtask

    task automatic send_pte(input logic [XLEN-1:0] pte);
        send_item(CMD_RESPONSE, $urandom, LEN_W'($urandom_range(0, 15)), pte);
    endtask

    // Hold until every expected result is out, then let the pipeline settle.
    task automatic drain(input int settle);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_root(input logic [PPN_W-1:0] ppn);
        drain(4);
        i_cfg_valid    <= 1'b1;
        i_cfg_root_ppn <= ppn;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid    <= 1'b0;
    endtask

    function automatic logic [XLEN-1:0] random_pte();
        logic [XLEN-1:0] pte;
        pte = $urandom;
        pte[0] = ($urandom_range(0, 7) != 0);
        return pte;
    endfunction

    task automatic random_walk();
        logic [XLEN-1:0]  va;
        logic [LEN_W-1:0] len;
        logic [XLEN-1:0]  pte;
        va = $urandom;
        // Park a quarter of the walks at the page end to hit the cross-page check.
        if ($urandom_range(0, 3) == 0) begin
            va[PAGE_OFS_W-1:0] = 12'hFF8 + 12'($urandom_range(0, 7));
        end
        len = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(0, 15))
                                          : LEN_W'($urandom_range(1, 8));
        send_translate(va, len);
        pte = random_pte();
        send_pte(pte);
        if (pte[0]) begin
            send_pte(random_pte());
        end
    endtask

    task automatic random_phase(input int idle_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = idle_pct;
        repeat (WALKS_PER_PHASE) begin
            if ($urandom_range(0, 6) == 0) begin
                send_item(1'($urandom_range(0, 1)), $urandom,
                          LEN_W'($urandom_range(0, 15)), $urandom);
            end else begin
                random_walk();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct  = 20;
        recv_stall_pct = 20;
        // Response while idle, then a request while a walk is in flight.
        send_pte($urandom);
        send_translate(32'h0000_0000, 4'd1);
        send_translate(32'hFFFF_FFFF, 4'd8);
        send_pte(32'h0000_0001);
        send_pte(32'hFFFF_FFFF);
        // Invalid level-1 entry.
        send_translate(32'hFFFF_FFFF, 4'd8);
        send_pte(32'h0000_0000);
        // Access that ends exactly on the page boundary.
        send_translate(32'h0000_0FF8, 4'd8);
        send_pte(32'h0000_0001);
        send_pte(32'h0000_0401);
        // One byte past the boundary.
        send_translate(32'h0000_0FF9, 4'd8);
        send_pte(32'hFFFF_FC01);
        send_pte(32'h0000_0001);
        // Invalid level-0 entry, zero length.
        send_translate(32'h1234_5FFF, 4'd0);
        send_pte(32'h0000_0001);
        send_pte(32'hFFFF_FFFE);
        // Length above eight.
        send_translate(32'hABCD_EFFF, 4'd15);
        send_pte(32'h0000_0001);
        send_pte(32'h0000_0001);

        // Top root page: table addresses wrap past 32 bits.
        write_root('1);
        send_translate(32'hFFFF_FFFF, 4'd8);
        send_pte(32'hFFFF_FFFF);
        send_pte(32'hFFFF_FFFF);
        send_translate(32'h0000_0000, 4'd8);
        send_pte(32'h0000_0001);
        send_pte(32'h8000_0001);

        write_root(PPN_W'($urandom));
        random_phase(25);
        write_root('0);
        random_phase(0);
        write_root(PPN_W'($urandom));
        random_phase(40);
        write_root('1);
        random_phase(0);

        drain(8);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sv32_page_table_walker_top.f */
src/sv32ptw_pkg.sv
src/sv32ptw_walk.sv
src/sv32ptw_out_reg.sv
src/sv32_page_table_walker_top.sv
dv/ptw_walk_checker.sv
dv/testbench.sv
